FILE: hdl/sync_length_sum_frame_parser_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sync/length/sum frame parser
// Concurrent checks in simulation, empty bodies for synthesis.
// ---------------------------------------------------------------------------
`ifndef SYNC_LENGTH_SUM_FRAME_PARSER_UNIT_DEFINES_SVH
`define SYNC_LENGTH_SUM_FRAME_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SLSFP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slsfp: same-cycle check failed");
// next-cycle implication
`define SLSFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slsfp: next-cycle check failed");
`else
`define SLSFP_ASSERT_SAME(label, clk, rst, ante, cons)
`define SLSFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/slsfp_pkg.sv
// ---------------------------------------------------------------------------
// slsfp_pkg
// Shared types and constants of the frame parser.
// ---------------------------------------------------------------------------
package slsfp_pkg;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 6;
   localparam int INDEX_W = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_LIMIT = 2'd2;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET   = 8'd170;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET  = 8'd85;
   localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RESET = 6'd32;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_SYNC2,
      ST_CMD,
      ST_LEN,
      ST_PAYLOAD,
      ST_CHECK,
      ST_EMIT_RD,
      ST_EMIT_WR
   } slsfp_state_type;

   typedef struct packed {
      logic req_ready;
      logic load_cmd;
      logic load_len;
      logic store_byte;
      logic start_emit;
      logic rd_en;
      logic load_out;
   } slsfp_cmd_type;

   typedef struct packed {
      logic sync1_hit;
      logic sync2_hit;
      logic len_too_big;
      logic len_zero;
      logic count_done;
      logic sum_hit;
      logic out_free;
      logic idx_last;
   } slsfp_status_type;

endpackage

FILE: hdl/slsfp_req_if.sv
// ---------------------------------------------------------------------------
// slsfp_req_if
// Received-byte channel: valid, ready and one byte.
// ---------------------------------------------------------------------------
interface slsfp_req_if;
   import slsfp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/slsfp_rsp_if.sv
// ---------------------------------------------------------------------------
// slsfp_rsp_if
// Result channel: one payload byte of a verified frame per item.
// ---------------------------------------------------------------------------
interface slsfp_rsp_if;
   import slsfp_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  command;
   logic [LEN_W-1:0]   frame_length;
   logic [INDEX_W-1:0] byte_index;
   logic [BYTE_W-1:0]  payload_byte;
   logic               last;

   modport source (output valid, output command, output frame_length, output byte_index,
                   output payload_byte, output last, input ready);
   modport sink   (input valid, input command, input frame_length, input byte_index,
                   input payload_byte, input last, output ready);
endinterface

FILE: hdl/slsfp_ram.sv
// ---------------------------------------------------------------------------
// slsfp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module slsfp_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/slsfp_ctrl.sv
// ---------------------------------------------------------------------------
// slsfp_ctrl
// Frame phase sequencer and result emission sequencer.
// ---------------------------------------------------------------------------
module slsfp_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  slsfp_pkg::slsfp_status_type status,
   output slsfp_pkg::slsfp_cmd_type    cmd
);
   import slsfp_pkg::*;

   slsfp_state_type state_ff;
   slsfp_state_type state_in;
   logic            take_ready;
   logic            accept;

   always_comb begin
      take_ready = !(state_ff == ST_EMIT_RD || state_ff == ST_EMIT_WR);
   end

   assign accept = req_valid && take_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_HUNT: begin
            if (accept && status.sync1_hit) state_in = ST_SYNC2;
         end
         ST_SYNC2: begin
            if (accept) state_in = status.sync2_hit ? ST_CMD : ST_HUNT;
         end
         ST_CMD: begin
            if (accept) state_in = ST_LEN;
         end
         ST_LEN: begin
            if (accept) begin
               if (status.len_too_big) state_in = ST_HUNT;
               else if (status.len_zero) state_in = ST_CHECK;
               else state_in = ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            if (accept && status.count_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (accept) state_in = status.sum_hit ? ST_EMIT_RD : ST_HUNT;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (status.out_free) state_in = status.idx_last ? ST_HUNT : ST_EMIT_RD;
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.req_ready  = take_ready;
      unique case (state_ff)
         ST_CMD:     cmd.load_cmd   = accept;
         ST_LEN:     cmd.load_len   = accept;
         ST_PAYLOAD: cmd.store_byte = accept;
         ST_CHECK:   cmd.start_emit = accept && status.sum_hit;
         ST_EMIT_RD: cmd.rd_en      = 1'b1;
         ST_EMIT_WR: cmd.load_out   = status.out_free;
         default:    cmd.req_ready  = take_ready;
      endcase
   end

endmodule

FILE: hdl/slsfp_dpath.sv
// ---------------------------------------------------------------------------
// slsfp_dpath
// Config registers, frame header, checksum, payload store and output register.
// ---------------------------------------------------------------------------
module slsfp_dpath #(
   parameter int MAX_BYTES = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [slsfp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [slsfp_pkg::BYTE_W-1:0]         csr_wdata,
   input  logic [slsfp_pkg::BYTE_W-1:0]         rx_byte,
   input  logic                                 rsp_ready,
   input  slsfp_pkg::slsfp_cmd_type             cmd,
   output slsfp_pkg::slsfp_status_type          status,
   output logic                                 rsp_valid,
   output logic [slsfp_pkg::BYTE_W-1:0]         rsp_command,
   output logic [slsfp_pkg::LEN_W-1:0]          rsp_frame_length,
   output logic [slsfp_pkg::INDEX_W-1:0]        rsp_byte_index,
   output logic [slsfp_pkg::BYTE_W-1:0]         rsp_payload_byte,
   output logic                                 rsp_last
);
   import slsfp_pkg::*;

   localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam logic [LEN_W:0] MAX_LEN = (LEN_W + 1)'(MAX_BYTES);

   logic [BYTE_W-1:0]  sync_first_ff;
   logic [BYTE_W-1:0]  sync_second_ff;
   logic [LEN_W-1:0]   length_limit_ff;
   logic [BYTE_W-1:0]  held_command_ff;
   logic [LEN_W-1:0]   held_length_ff;
   logic [LEN_W-1:0]   count_ff;
   logic [BYTE_W-1:0]  sum_ff;
   logic [LEN_W-1:0]   rd_idx_ff;
   logic               out_valid_ff;
   logic [BYTE_W-1:0]  out_command_ff;
   logic [LEN_W-1:0]   out_length_ff;
   logic [INDEX_W-1:0] out_index_ff;
   logic [BYTE_W-1:0]  out_payload_ff;
   logic               out_last_ff;

   logic [LEN_W:0]     eff_limit;
   logic [LEN_W:0]     count_next;
   logic [LEN_W:0]     idx_next;
   logic [BYTE_W-1:0]  rd_data;

   // limit is the smaller of the register and the store depth
   always_comb begin
      eff_limit  = ({1'b0, length_limit_ff} > MAX_LEN) ? MAX_LEN : {1'b0, length_limit_ff};
      count_next = {1'b0, count_ff} + 1'b1;
      idx_next   = {1'b0, rd_idx_ff} + 1'b1;
   end

   always_comb begin
      status.sync1_hit   = (rx_byte == sync_first_ff);
      status.sync2_hit   = (rx_byte == sync_second_ff);
      status.len_too_big = ({1'b0, rx_byte} > {2'b00, eff_limit});
      status.len_zero    = (rx_byte == '0);
      status.count_done  = (count_next >= {1'b0, held_length_ff});
      status.sum_hit     = (rx_byte == sum_ff);
      status.out_free    = !out_valid_ff || rsp_ready;
      status.idx_last    = (held_length_ff == '0) || (idx_next == {1'b0, held_length_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff   <= SYNC_FIRST_RESET;
         sync_second_ff  <= SYNC_SECOND_RESET;
         length_limit_ff <= LENGTH_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:   sync_first_ff   <= csr_wdata;
            CSR_SYNC_SECOND:  sync_second_ff  <= csr_wdata;
            CSR_LENGTH_LIMIT: length_limit_ff <= csr_wdata[LEN_W-1:0];
            default:          sync_first_ff   <= sync_first_ff;
         endcase
      end
   end

   // header, checksum and read pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         held_command_ff <= '0;
         held_length_ff  <= '0;
         count_ff        <= '0;
         sum_ff          <= '0;
         rd_idx_ff       <= '0;
      end else begin
         if (cmd.load_cmd) begin
            held_command_ff <= rx_byte;
            sum_ff          <= rx_byte;
         end
         if (cmd.load_len) begin
            sum_ff <= sum_ff + rx_byte;
            if (!status.len_too_big) begin
               held_length_ff <= rx_byte[LEN_W-1:0];
               count_ff       <= '0;
            end
         end
         if (cmd.store_byte) begin
            sum_ff   <= sum_ff + rx_byte;
            count_ff <= count_next[LEN_W-1:0];
         end
         if (cmd.start_emit) begin
            rd_idx_ff <= '0;
         end else if (cmd.load_out) begin
            rd_idx_ff <= idx_next[LEN_W-1:0];
         end
      end
   end

   slsfp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store_byte),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_command_ff <= held_command_ff;
         out_length_ff  <= held_length_ff;
         out_index_ff   <= rd_idx_ff[INDEX_W-1:0];
         out_payload_ff <= (held_length_ff == '0) ? '0 : rd_data;
         out_last_ff    <= status.idx_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_command      = out_command_ff;
   assign rsp_frame_length = out_length_ff;
   assign rsp_byte_index   = out_index_ff;
   assign rsp_payload_byte = out_payload_ff;
   assign rsp_last         = out_last_ff;

endmodule

FILE: hdl/sync_length_sum_frame_parser_unit.sv
// ---------------------------------------------------------------------------
// sync_length_sum_frame_parser_unit
// Byte-stream frame parser: sync, sync, command, length, payload, sum.
// req_bus takes one received byte per item; it is accepted in the cycle it is
// offered whenever the parser is collecting a frame. A frame whose 8-bit sum of
// command, length and payload matches its last byte is replayed on rsp_bus
// as one item per payload byte (one item for an empty frame), tagged with
// command, length and index; last marks the final item of the run.
// Each item is replayed by the registered read of the payload store
// followed by the load of the output register. req_bus.ready is low
// during the replay; the first item follows the sum byte through both steps.
// A stalled rsp_bus holds the output register and the replay waits; the
// next frame's bytes are accepted while the final item is still pending.
// Reset restores the sync bytes and length limit and returns to hunting; the
// payload store is not cleared. csr_* writes must come while idle (unchecked).
// ---------------------------------------------------------------------------
`include "sync_length_sum_frame_parser_unit_defines.svh"

module sync_length_sum_frame_parser_unit #(
   parameter int MAX_BYTES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   slsfp_req_if.sink                       req_bus,
   slsfp_rsp_if.source                     rsp_bus,
   input  logic                            csr_we,
   input  logic [slsfp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [slsfp_pkg::BYTE_W-1:0]    csr_wdata
);
   import slsfp_pkg::*;

   slsfp_cmd_type    cmd;
   slsfp_status_type status;

   // controller: frame phases and replay sequencing
   slsfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: registers, checksum, store and the output register
   slsfp_dpath #(
      .MAX_BYTES (MAX_BYTES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rx_byte          (req_bus.rx_byte),
      .rsp_ready        (rsp_bus.ready),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_bus.valid),
      .rsp_command      (rsp_bus.command),
      .rsp_frame_length (rsp_bus.frame_length),
      .rsp_byte_index   (rsp_bus.byte_index),
      .rsp_payload_byte (rsp_bus.payload_byte),
      .rsp_last         (rsp_bus.last)
   );

   // hold off input during replay
   assign req_bus.ready = cmd.req_ready;

   // no store read while input bytes are being taken
   `SLSFP_ASSERT_SAME(a_read_blocks_input, clock, reset, cmd.rd_en, !req_bus.ready)
   // never overwrite an item still waiting on rsp_bus
   `SLSFP_ASSERT_SAME(a_load_when_free, clock, reset, cmd.load_out, status.out_free)
   // after the final item is loaded, resume hunting at once
   `SLSFP_ASSERT_NEXT(a_resume_after_last, clock, reset, cmd.load_out && status.idx_last, req_bus.ready)

endmodule

FILE: tb/slsfp_tb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slsfp_tb_pkg
// Frame scoreboard for the sync/length/sum frame parser: tracks the parser
// state byte by byte, queues the payload replay of every verified frame and
// checks each result item against it.
// ---------------------------------------------------------------------------
package slsfp_tb_pkg;
   import slsfp_pkg::*;

   localparam int FRAME_MAX_BYTES = 32;
   localparam int REPORT_LIMIT    = 10;

   typedef logic [BYTE_W-1:0] byte_queue_type[$];

   typedef struct packed {
      logic [BYTE_W-1:0]  command;
      logic [LEN_W-1:0]   frame_length;
      logic [INDEX_W-1:0] byte_index;
      logic [BYTE_W-1:0]  payload_byte;
      logic               last;
   } replay_item_type;

   class frame_scoreboard;
      logic [BYTE_W-1:0] sync_first_q;
      logic [BYTE_W-1:0] sync_second_q;
      logic [LEN_W-1:0]  length_limit_q;

      slsfp_state_type   phase;
      logic [BYTE_W-1:0] held_command;
      logic [LEN_W-1:0]  held_length;
      logic [LEN_W-1:0]  received_count;
      logic [BYTE_W-1:0] running_sum;
      logic [BYTE_W-1:0] payload_store [FRAME_MAX_BYTES];

      replay_item_type   replay_q[$];
      int unsigned       replays_predicted;
      int unsigned       failures;

      function new();
         sync_first_q      = SYNC_FIRST_RESET;
         sync_second_q     = SYNC_SECOND_RESET;
         length_limit_q    = LENGTH_LIMIT_RESET;
         phase             = ST_HUNT;
         held_command      = '0;
         held_length       = '0;
         received_count    = '0;
         running_sum       = '0;
         replays_predicted = 0;
         failures          = 0;
         foreach (payload_store[i]) payload_store[i] = '0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [BYTE_W-1:0] value);
         case (index)
            CSR_SYNC_FIRST:   sync_first_q = value;
            CSR_SYNC_SECOND:  sync_second_q = value;
            CSR_LENGTH_LIMIT: length_limit_q = value[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function int effective_limit();
         return (length_limit_q > FRAME_MAX_BYTES) ? FRAME_MAX_BYTES : int'(length_limit_q);
      endfunction

      function bit hunting();
         return phase == ST_HUNT;
      endfunction

      function int pending();
         return replay_q.size();
      endfunction

      // one item per stored byte, or a single empty item for a zero-length frame
      function void queue_replay();
         int n;
         n = (held_length > FRAME_MAX_BYTES) ? FRAME_MAX_BYTES : int'(held_length);
         if (n == 0) begin
            replay_q.push_back({held_command, 6'd0, 5'd0, 8'd0, 1'b1});
            replays_predicted++;
         end else begin
            for (int i = 0; i < n; i++) begin
               replay_q.push_back({held_command, held_length, 5'(i), payload_store[i],
                                   i == n - 1});
               replays_predicted++;
            end
         end
      endfunction

      function void note_rx_byte(logic [BYTE_W-1:0] b);
         case (phase)
            ST_HUNT: begin
               if (b == sync_first_q) phase = ST_SYNC2;
            end
            ST_SYNC2: begin
               // a wrong second byte is not retried as a first sync byte
               phase = (b == sync_second_q) ? ST_CMD : ST_HUNT;
            end
            ST_CMD: begin
               held_command = b;
               running_sum  = b;
               phase        = ST_LEN;
            end
            ST_LEN: begin
               running_sum = running_sum + b;
               if (int'(b) > effective_limit()) begin
                  phase = ST_HUNT;
               end else begin
                  held_length    = b[LEN_W-1:0];
                  received_count = '0;
                  phase          = (b == 8'd0) ? ST_CHECK : ST_PAYLOAD;
               end
            end
            ST_PAYLOAD: begin
               if (received_count < FRAME_MAX_BYTES) payload_store[received_count] = b;
               received_count = received_count + 1'b1;
               running_sum    = running_sum + b;
               if (received_count >= held_length) phase = ST_CHECK;
            end
            ST_CHECK: begin
               if (b == running_sum) queue_replay();
               phase = ST_HUNT;
            end
            default: phase = ST_HUNT;
         endcase
      endfunction

      function void check_payload_item(replay_item_type got);
         replay_item_type want;
         bit              bad;
         if (replay_q.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected result: cmd %h len %0d idx %0d byte %h last %b",
                        got.command, got.frame_length, got.byte_index, got.payload_byte,
                        got.last);
            return;
         end
         want = replay_q.pop_front();
         bad = (got.command !== want.command) || (got.frame_length !== want.frame_length) ||
               (got.byte_index !== want.byte_index) ||
               (got.payload_byte !== want.payload_byte) || (got.last !== want.last);
         if (bad) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $write("replay mismatch: expected cmd %h len %0d idx %0d byte %h last %b,",
                      want.command, want.frame_length, want.byte_index, want.payload_byte,
                      want.last);
               $display(" got cmd %h len %0d idx %0d byte %h last %b",
                        got.command, got.frame_length, got.byte_index, got.payload_byte,
                        got.last);
            end
         end
      endfunction

      // leftover replay items count as a failure
      function int unsigned close_out();
         if (replay_q.size() != 0) begin
            failures++;
            $display("%0d expected result items never arrived", replay_q.size());
         end
         return failures;
      endfunction
   endclass

endpackage

FILE: tb/sync_length_sum_frame_parser_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sync_length_sum_frame_parser_unit_tb
// Feeds byte streams of good, corrupted, truncated and noise frames into the
// parser under four register settings, with random idling on both channels
// and a long result stall, and checks every replayed payload item against
// the frame scoreboard.
// ---------------------------------------------------------------------------
module sync_length_sum_frame_parser_unit_tb;
   import slsfp_pkg::*;
   import slsfp_tb_pkg::*;

   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int RSP_HOLD_CYCLES = 120;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 20;
   localparam int ITEM_TARGET     = 160;
   localparam int FRAME_CAP       = 600;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wdata;

   slsfp_req_if req_bus ();
   slsfp_rsp_if rsp_bus ();

   sync_length_sum_frame_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_scoreboard sb = new();

   // stimulus knobs shared with the result sink
   bit sender_gaps_on = 1'b0;
   bit idle_allowed   = 1'b1;
   bit rsp_idle_on    = 1'b1;
   bit rsp_hold_req   = 1'b0;
   int items_sent     = 0;
   int frames_sent    = 0;
   int stall_cycles   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [BYTE_W-1:0] rand_byte();
      return 8'($urandom);
   endfunction

   // sync, sync, command, length, payload, then the 8-bit sum of all but the syncs
   function automatic byte_queue_type build_frame(logic [BYTE_W-1:0] s1,
                                                  logic [BYTE_W-1:0] s2,
                                                  logic [BYTE_W-1:0] cmd,
                                                  logic [BYTE_W-1:0] len,
                                                  byte_queue_type body);
      byte_queue_type    f;
      logic [BYTE_W-1:0] sum;
      sum = cmd + len;
      f = {s1, s2, cmd, len};
      foreach (body[i]) begin
         f.push_back(body[i]);
         sum = sum + body[i];
      end
      f.push_back(sum);
      return f;
   endfunction

   function automatic byte_queue_type random_body(int len);
      byte_queue_type body;
      repeat (len) body.push_back(rand_byte());
      return body;
   endfunction

   // mostly short payloads, now and then anything up to the limit
   function automatic int pick_length(int lim);
      if (lim == 0) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, (lim < 6) ? lim : 6);
      return $urandom_range(0, lim);
   endfunction

   // Drive one byte at the falling edge and hold it until the parser takes it.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (sender_gaps_on && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_bus.valid   <= 1'b0;
         req_bus.rx_byte <= rand_byte();
         repeat ($urandom_range(0, 16)) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_rx_byte(b);
   endtask

   task automatic send_stream(input byte_queue_type bytes, input bit counted);
      foreach (bytes[i]) begin
         send_byte(bytes[i]);
         if (counted) items_sent++;
      end
   endtask

   // Flush a half-received frame with filler until the parser hunts again.
   task automatic return_to_hunt();
      while (!sb.hunting()) begin
         send_byte(rand_byte());
         items_sent++;
      end
   endtask

   // Drop valid, then hold off until every predicted item has come back and
   // the parser has had time to finish whatever it was still working on.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [BYTE_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.write_register(index, value);
   endtask

   task automatic write_settings(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                                 input logic [BYTE_W-1:0] lim);
      write_csr(CSR_SYNC_FIRST, s1);
      write_csr(CSR_SYNC_SECOND, s2);
      write_csr(CSR_LENGTH_LIMIT, lim);
   endtask

   // One random frame: mostly well formed, the rest corrupted, cut short or noise.
   task automatic random_frame();
      int                kind;
      int                lim;
      int                cut;
      byte_queue_type    f;
      logic [BYTE_W-1:0] b;
      return_to_hunt();
      sender_gaps_on = idle_allowed && ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      lim  = sb.effective_limit();
      f = build_frame(sb.sync_first_q, sb.sync_second_q, rand_byte(),
                      8'(pick_length(lim)), random_body(0));
      // rebuild with a body that matches the length byte
      f = build_frame(sb.sync_first_q, sb.sync_second_q, f[2], f[3], random_body(int'(f[3])));
      if (kind < 64) begin
         send_stream(f, 1'b1);
      end else if (kind < 74) begin
         // corrupt the sum byte by one bit
         f[f.size() - 1] = f[f.size() - 1] ^ (8'd1 << $urandom_range(0, 7));
         send_stream(f, 1'b1);
      end else if (kind < 81) begin
         // wrong second sync byte
         send_stream({sb.sync_first_q, sb.sync_second_q ^ (8'd1 << $urandom_range(0, 7))},
                     1'b1);
      end else if (kind < 88) begin
         // length above the limit abandons the frame
         send_stream({sb.sync_first_q, sb.sync_second_q, rand_byte(),
                      8'($urandom_range(lim + 1, 255))}, 1'b1);
      end else if (kind < 95) begin
         // cut short; the next frame's header lands in this one
         cut = $urandom_range(3, f.size() - 1);
         f = f[0:cut-1];
         send_stream(f, 1'b1);
      end else begin
         // line noise while hunting, never the first sync byte
         repeat ($urandom_range(1, 6)) begin
            b = rand_byte();
            if (b == sb.sync_first_q) b = ~b;
            send_byte(b);
            items_sent++;
         end
      end
      frames_sent++;
   endtask

   task automatic run_random(input int target);
      while (items_sent < target && frames_sent < FRAME_CAP) random_frame();
   endtask

   // Result sink: random ready, random idle bursts, and a long
   // hold-off on request, counted here.
   initial begin : result_sink
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            rsp_hold_req = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(0, 24)) @(negedge clock);
         end
      end
   end

   // Check every accepted result item against the oldest predicted one.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_payload_item({rsp_bus.command, rsp_bus.frame_length, rsp_bus.byte_index,
                                rsp_bus.payload_byte, rsp_bus.last});
   end

   // Watchdog: too long without any item moving on either channel.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles = 0;
      else
         stall_cycles = stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("sync_length_sum_frame_parser_unit_tb: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      byte_queue_type    bad_sum;
      logic [BYTE_W-1:0] s1;
      int                extra_len;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      csr_we          = 1'b0;
      csr_index       = CSR_SYNC_FIRST;
      csr_wdata       = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames at the reset settings.
      // empty frame, all-zero command and sum: one item
      send_stream(build_frame(SYNC_FIRST_RESET, SYNC_SECOND_RESET, 8'h00, 8'h00,
                              random_body(0)), 1'b1);
      // one all-ones payload byte under an all-ones command
      send_stream(build_frame(SYNC_FIRST_RESET, SYNC_SECOND_RESET, 8'hFF, 8'h01, {8'hFF}),
                  1'b1);
      // repeated first sync: the second copy is a bad second sync and the
      // real second sync that follows is ignored
      send_stream({SYNC_FIRST_RESET, SYNC_FIRST_RESET, SYNC_SECOND_RESET}, 1'b1);
      // length one above the limit
      send_stream({SYNC_FIRST_RESET, SYNC_SECOND_RESET, 8'h07, 8'd33}, 1'b1);
      // checksum off by one: nothing comes out
      bad_sum = build_frame(SYNC_FIRST_RESET, SYNC_SECOND_RESET, 8'h10, 8'h02,
                            {8'h01, 8'h02});
      bad_sum[bad_sum.size() - 1] = bad_sum[bad_sum.size() - 1] - 8'd1;
      send_stream(bad_sum, 1'b1);

      run_random(45);

      // Low syncs / high syncs, limit zero: only empty frames pass.
      wait_drained();
      write_settings(8'h00, 8'hFF, 8'd0);
      run_random(70);

      // Inverted syncs, full limit.
      wait_drained();
      write_settings(8'hFF, 8'h00, 8'd32);
      return_to_hunt();
      // Stall the result side while a full-size frame and two more arrive,
      // so the replay backs up into the input.
      sender_gaps_on = 1'b0;
      rsp_hold_req   = 1'b1;
      send_stream(build_frame(sb.sync_first_q, sb.sync_second_q, rand_byte(), 8'd32,
                              random_body(32)), 1'b1);
      repeat (2) begin
         extra_len = $urandom_range(1, 8);
         send_stream(build_frame(sb.sync_first_q, sb.sync_second_q, rand_byte(),
                                 8'(extra_len), random_body(extra_len)), 1'b1);
      end
      run_random(110);

      // Random syncs, sometimes equal, and a random nonzero limit.
      wait_drained();
      s1 = rand_byte();
      write_settings(s1, ($urandom_range(0, 3) == 0) ? s1 : rand_byte(),
                     8'($urandom_range(1, 31)));
      run_random(125);
      wait_drained();
      run_random(135);

      // Last stretch: no idling on either side.
      idle_allowed = 1'b0;
      rsp_idle_on  = 1'b0;
      while (items_sent < ITEM_TARGET && frames_sent < FRAME_CAP)
         random_frame();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.close_out() == 0)
         $display("sync_length_sum_frame_parser_unit_tb: done, clean");
      else
         $display("sync_length_sum_frame_parser_unit_tb: done, errors");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/slsfp_pkg.sv
hdl/slsfp_req_if.sv
hdl/slsfp_rsp_if.sv
hdl/slsfp_ram.sv
hdl/slsfp_ctrl.sv
hdl/slsfp_dpath.sv
hdl/sync_length_sum_frame_parser_unit.sv
tb/slsfp_tb_pkg.sv
tb/sync_length_sum_frame_parser_unit_tb.sv
